// ----- rtl/hvd_pkg.sv -----
// ----------------------------------------------------------------------------
// hvd_pkg: shared types and constants for the great-circle distance block
// fixed-point formats, cordic and square-root cell payloads, arctangent table
// ----------------------------------------------------------------------------
package hvd_pkg;

    localparam int CORDIC_STAGES_DEF = 32;
    localparam int SQRT_STAGES       = 32;
    localparam int CW                = 36;   // cordic datapath width
    localparam int LAT_W             = 31;
    localparam int LON_W             = 32;
    localparam int DIST_W            = 25;

    localparam logic [30:0] RAD_PER_UNIT_Q60 = 31'd2012227627;
    localparam logic [32:0] Q_ONE            = 33'h1_0000_0000;
    localparam logic [31:0] MAG_MAX          = 32'hFFFF_FFFF;
    localparam logic [23:0] EARTH_DIAMETER_M = 24'd12742000;
    localparam logic [32:0] HALF_TURN_UNITS  = 33'd1800000000;
    localparam logic [32:0] FULL_TURN_UNITS  = 33'd3600000000;
    localparam logic [30:0] QUARTER_UNITS    = 31'd900000000;
    localparam logic [30:0] HALF_UNITS_31    = 31'd1800000000;

    typedef logic signed [CW-1:0] cval_t;

    localparam cval_t CORDIC_GAIN_INV = 36'sd2608131496;

    typedef struct packed {
        cval_t x;
        cval_t y;
        cval_t z;
    } cordic_t;

    typedef struct packed {
        logic [63:0] v;
        logic [63:0] res;
        logic        one;
    } sqrt_t;

    // atan(2^-i) in q.32
    function automatic cval_t atan_q32(input int i);
        cval_t r;
        case (i)
            0:  r = 36'sd3373259426;
            1:  r = 36'sd1991351318;
            2:  r = 36'sd1052175346;
            3:  r = 36'sd534100635;
            4:  r = 36'sd268086748;
            5:  r = 36'sd134174063;
            6:  r = 36'sd67103403;
            7:  r = 36'sd33553749;
            8:  r = 36'sd16777131;
            9:  r = 36'sd8388597;
            10: r = 36'sd4194303;
            default: begin
                if (i <= 32) begin
                    r = cval_t'(1) <<< (32 - i);
                end else begin
                    r = '0;
                end
            end
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/haversine_distance.sv -----
// ----------------------------------------------------------------------------
// haversine_distance: great-circle distance between two positions
// fixed-point haversine with cordic sine/cosine, integer root and cordic arcsine
// ----------------------------------------------------------------------------
// Takes one pair of positions per transfer (latitude and longitude in 1e-7
// degree) and returns the great-circle distance on a 6371 km sphere in whole
// metres, rounded to nearest. The datapath is a fully pipelined row of cells:
// four cordic rotation chains (cosine of each latitude, sine of each half
// difference), two 32-cell square-root chains and one cordic vectoring chain
// for the arcsine, with a few multiply and rounding stages between them. A new
// pair is taken every cycle while the row is not stalled; the latency grows
// with the length of the cordic chains and the root chain. The whole row
// advances together; it stalls only while the output register holds an
// untaken result and the last stage also holds one, so idle slots in the
// pipe are squeezed out at the output.
// ----------------------------------------------------------------------------
module haversine_distance import hvd_pkg::*; #(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [30:0] first_lat, [62:31] first_lon, [93:63] second_lat, [125:94] second_lon
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [24:0] distance_m
    output logic [31:0]  m_tdata
);

    localparam int CS = CORDIC_STAGES;

    // fold |lat| into [0, 90 deg]; top bit flags a negated cosine
    function automatic logic [31:0] cos_fold(input logic signed [LAT_W-1:0] u);
        logic [30:0] a;
        logic        n;
        a = u[LAT_W-1] ? 31'(-u) : 31'(u);
        n = 1'b0;
        if (a > QUARTER_UNITS) begin
            a = HALF_UNITS_31 - a;
            n = 1'b1;
        end
        return {n, a};
    endfunction

    // fold a difference into [0, 180 deg] without changing sin^2(d/2)
    function automatic logic [30:0] sin_fold(input logic signed [32:0] d);
        logic [32:0] a;
        a = d[32] ? 33'(-d) : 33'(d);
        if (a > HALF_TURN_UNITS) begin
            a = (a >= FULL_TURN_UNITS) ? a - FULL_TURN_UNITS : FULL_TURN_UNITS - a;
        end
        return a[30:0];
    endfunction

    // product to q3.32 radians, rounded; half selects the half angle
    function automatic cval_t to_angle(input logic [61:0] p, input logic half);
        logic [62:0] s;
        if (half) begin
            s = 63'(p) + (63'd1 << 28);
            return cval_t'(s >> 29);
        end else begin
            s = 63'(p) + (63'd1 << 27);
            return cval_t'(s >> 28);
        end
    endfunction

    function automatic logic [31:0] mag_sat(input cval_t v);
        logic [CW-1:0] a;
        a = (v < 0) ? CW'(-v) : CW'(v);
        return (a > CW'(MAG_MAX)) ? MAG_MAX : a[31:0];
    endfunction

    function automatic logic [31:0] rnd_q32(input logic [63:0] p);
        logic [64:0] s;
        s = 65'(p) + 65'h8000_0000;
        return s[63:32];
    endfunction

    function automatic sqrt_t sqrt_init(input logic [32:0] val);
        sqrt_t r;
        r.one = val[32];
        r.v   = {val[31:0], 32'd0};
        r.res = '0;
        return r;
    endfunction

    // stall control: output register and last stage
    logic en;
    logic out_load;

    // input stage
    logic                    in_vld_reg;
    logic signed [LAT_W-1:0] lat1_reg;
    logic signed [LON_W-1:0] lon1_reg;
    logic signed [LAT_W-1:0] lat2_reg;
    logic signed [LON_W-1:0] lon2_reg;

    // folding stage
    logic        fold_vld_reg;
    logic [30:0] ang_u_reg [4];
    logic        fold_n1_reg;
    logic        fold_n2_reg;
    logic [31:0] cf1;
    logic [31:0] cf2;
    logic signed [32:0] dlat;
    logic signed [32:0] dlon;

    // angle multiply stage
    logic        prod_vld_reg;
    logic [61:0] prod_reg [4];
    logic        prod_n1_reg;
    logic        prod_n2_reg;

    // rotation chains: 0 cos lat1, 1 cos lat2, 2 sin dlat/2, 3 sin dlon/2
    cordic_t rot0_reg [4];
    cordic_t rot_c [4][0:CS];
    logic    rot_vld_reg [0:CS];
    logic    rot_n1_reg [0:CS];
    logic    rot_n2_reg [0:CS];

    // magnitudes
    logic        mag_vld_reg;
    logic [31:0] mag_c1_reg;
    logic [31:0] mag_c2_reg;
    logic [31:0] mag_sa_reg;
    logic [31:0] mag_so_reg;
    logic        mag_neq_reg;

    // products
    logic        mul_vld_reg;
    logic [63:0] p_cc_reg;
    logic [63:0] p_aa_reg;
    logic [63:0] p_oo_reg;
    logic        mul_neq_reg;

    logic        rnd_vld_reg;
    logic [31:0] cc_reg;
    logic [31:0] sa2_reg;
    logic [31:0] oo_reg;
    logic        rnd_neq_reg;

    logic        t_vld_reg;
    logic [63:0] t_raw_reg;
    logic [31:0] t_sa2_reg;
    logic        t_neq_reg;

    // haversine term
    logic        h_vld_reg;
    logic [32:0] h_reg;
    logic [32:0] h_next;
    logic [31:0] t_val;

    // root chains: 0 sqrt(1-h), 1 sqrt(h)
    sqrt_t sq0_reg [2];
    sqrt_t sq_c [2][0:SQRT_STAGES];
    logic  sq_vld_reg [0:SQRT_STAGES];

    // vectoring chain
    cordic_t vec0_reg;
    cordic_t vec_c [0:CS];
    logic    vec_vld_reg [0:CS];
    cval_t   z_fin;

    // scale to metres
    logic        fin_vld_reg;
    logic [56:0] fin_prod_reg;
    logic [57:0] fin_sum;

    logic              out_vld_reg;
    logic [DIST_W-1:0] out_dist_reg;

    assign out_load = !out_vld_reg || m_tready;
    assign en       = out_load || !fin_vld_reg;
    assign s_tready = en;

    // ---- input capture ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (en) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lat1_reg <= s_tdata[30:0];
            lon1_reg <= s_tdata[62:31];
            lat2_reg <= s_tdata[93:63];
            lon2_reg <= s_tdata[125:94];
        end
    end

    // ---- fold angles into the cordic range ----
    // differences at 33 bits so they never wrap
    assign cf1  = cos_fold(lat1_reg);
    assign cf2  = cos_fold(lat2_reg);
    assign dlat = 33'(lat2_reg) - 33'(lat1_reg);
    assign dlon = 33'(lon2_reg) - 33'(lon1_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fold_vld_reg <= 1'b0;
        end else if (en) begin
            fold_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ang_u_reg[0] <= cf1[30:0];
            ang_u_reg[1] <= cf2[30:0];
            ang_u_reg[2] <= sin_fold(dlat);
            ang_u_reg[3] <= sin_fold(dlon);
            fold_n1_reg  <= cf1[31];
            fold_n2_reg  <= cf2[31];
        end
    end

    // ---- units to radians: one multiplier per chain ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else if (en) begin
            prod_vld_reg <= fold_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                prod_reg[k] <= 62'(ang_u_reg[k]) * 62'(RAD_PER_UNIT_Q60);
            end
            prod_n1_reg <= fold_n1_reg;
            prod_n2_reg <= fold_n2_reg;
        end
    end

    // ---- rotation chains ----
    // full angle for the latitude cosines, half angle for the differences
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                rot0_reg[k].x <= CORDIC_GAIN_INV;
                rot0_reg[k].y <= '0;
                rot0_reg[k].z <= to_angle(prod_reg[k], k >= 2);
            end
        end
    end

    // sideband follows the chains: valid and the cosine sign flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= CS; i++) begin
                rot_vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            rot_vld_reg[0] <= prod_vld_reg;
            for (int i = 1; i <= CS; i++) begin
                rot_vld_reg[i] <= rot_vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rot_n1_reg[0] <= prod_n1_reg;
            rot_n2_reg[0] <= prod_n2_reg;
            for (int i = 1; i <= CS; i++) begin
                rot_n1_reg[i] <= rot_n1_reg[i-1];
                rot_n2_reg[i] <= rot_n2_reg[i-1];
            end
        end
    end

    for (genvar k = 0; k < 4; k++) begin : g_rot
        assign rot_c[k][0] = rot0_reg[k];
        for (genvar i = 0; i < CS; i++) begin : g_cell
            hvd_rot_cell #(
                .IDX (i)
            ) u_cell (
                .aclk  (aclk),
                .en    (en),
                .c_in  (rot_c[k][i]),
                .c_out (rot_c[k][i+1])
            );
        end
    end

    // ---- magnitudes, saturated to q0.32 ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mag_vld_reg <= 1'b0;
        end else if (en) begin
            mag_vld_reg <= rot_vld_reg[CS];
        end
    end

    // cosine sign: fold flag flipped by a negative cordic cosine
    always_ff @(posedge aclk) begin
        if (en) begin
            mag_c1_reg  <= mag_sat(rot_c[0][CS].x);
            mag_c2_reg  <= mag_sat(rot_c[1][CS].x);
            mag_sa_reg  <= mag_sat(rot_c[2][CS].y);
            mag_so_reg  <= mag_sat(rot_c[3][CS].y);
            mag_neq_reg <= (rot_n1_reg[CS] ^ (rot_c[0][CS].x < 0))
                         ^ (rot_n2_reg[CS] ^ (rot_c[1][CS].x < 0));
        end
    end

    // ---- products ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_vld_reg <= 1'b0;
            rnd_vld_reg <= 1'b0;
            t_vld_reg   <= 1'b0;
            h_vld_reg   <= 1'b0;
        end else if (en) begin
            mul_vld_reg <= mag_vld_reg;
            rnd_vld_reg <= mul_vld_reg;
            t_vld_reg   <= rnd_vld_reg;
            h_vld_reg   <= t_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_cc_reg    <= 64'(mag_c1_reg) * 64'(mag_c2_reg);
            p_aa_reg    <= 64'(mag_sa_reg) * 64'(mag_sa_reg);
            p_oo_reg    <= 64'(mag_so_reg) * 64'(mag_so_reg);
            mul_neq_reg <= mag_neq_reg;

            cc_reg      <= rnd_q32(p_cc_reg);
            sa2_reg     <= rnd_q32(p_aa_reg);
            oo_reg      <= rnd_q32(p_oo_reg);
            rnd_neq_reg <= mul_neq_reg;

            t_raw_reg   <= 64'(cc_reg) * 64'(oo_reg);
            t_sa2_reg   <= sa2_reg;
            t_neq_reg   <= rnd_neq_reg;

            h_reg       <= h_next;
        end
    end

    // h = sin^2(dlat/2) +- cos*cos*sin^2(dlon/2), clamped to [0, 1]
    assign t_val = rnd_q32(t_raw_reg);

    always_comb begin
        if (t_neq_reg) begin
            h_next = (t_sa2_reg >= t_val) ? 33'(t_sa2_reg - t_val) : '0;
        end else begin
            h_next = 33'(t_sa2_reg) + 33'(t_val);
        end
        if (h_next > Q_ONE) begin
            h_next = Q_ONE;
        end
    end

    // ---- square-root chains ----
    always_ff @(posedge aclk) begin
        if (en) begin
            sq0_reg[0] <= sqrt_init(Q_ONE - h_reg);
            sq0_reg[1] <= sqrt_init(h_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= SQRT_STAGES; i++) begin
                sq_vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            sq_vld_reg[0] <= h_vld_reg;
            for (int i = 1; i <= SQRT_STAGES; i++) begin
                sq_vld_reg[i] <= sq_vld_reg[i-1];
            end
        end
    end

    for (genvar k = 0; k < 2; k++) begin : g_sq
        assign sq_c[k][0] = sq0_reg[k];
        for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_cell
            hvd_sqrt_cell #(
                .IDX (i)
            ) u_cell (
                .aclk  (aclk),
                .en    (en),
                .s_in  (sq_c[k][i]),
                .s_out (sq_c[k][i+1])
            );
        end
    end

    // ---- arcsine by vectoring (sqrt(1-h), sqrt(h)) ----
    always_ff @(posedge aclk) begin
        if (en) begin
            vec0_reg.x <= cval_t'(sq_c[0][SQRT_STAGES].one
                                  ? Q_ONE : {1'b0, sq_c[0][SQRT_STAGES].res[31:0]});
            vec0_reg.y <= cval_t'(sq_c[1][SQRT_STAGES].one
                                  ? Q_ONE : {1'b0, sq_c[1][SQRT_STAGES].res[31:0]});
            vec0_reg.z <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= CS; i++) begin
                vec_vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vec_vld_reg[0] <= sq_vld_reg[SQRT_STAGES];
            for (int i = 1; i <= CS; i++) begin
                vec_vld_reg[i] <= vec_vld_reg[i-1];
            end
        end
    end

    assign vec_c[0] = vec0_reg;

    for (genvar i = 0; i < CS; i++) begin : g_vec
        hvd_vec_cell #(
            .IDX (i)
        ) u_cell (
            .aclk  (aclk),
            .en    (en),
            .c_in  (vec_c[i]),
            .c_out (vec_c[i+1])
        );
    end

    // ---- scale by the earth diameter, round to metres ----
    assign z_fin = (vec_c[CS].z < 0) ? '0 : vec_c[CS].z;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_vld_reg <= 1'b0;
        end else if (en) begin
            fin_vld_reg <= vec_vld_reg[CS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fin_prod_reg <= 57'(z_fin[32:0]) * 57'(EARTH_DIAMETER_M);
        end
    end

    assign fin_sum = 58'(fin_prod_reg) + 58'h8000_0000;

    // output register: loads when empty or when the held result is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_load) begin
            out_vld_reg <= fin_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_dist_reg <= fin_sum[56:32];
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(32 - DIST_W){1'b0}}, out_dist_reg};

    // ---- checks ----
    a_stall_only_on_held_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a held result");

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_h_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        h_vld_reg |-> (h_reg <= Q_ONE))
        else $error("haversine term above one");

    a_distance_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[24:0] <= 25'd22300000))
        else $error("distance beyond the arcsine range");

endmodule

// ----- rtl/hvd_rot_cell.sv -----
// ----------------------------------------------------------------------------
// hvd_rot_cell: one cordic rotation step
// rotates towards zero residual angle, registered output
// ----------------------------------------------------------------------------
module hvd_rot_cell import hvd_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic    aclk,
    input  logic    en,
    input  cordic_t c_in,
    output cordic_t c_out
);

    localparam cval_t ATAN = atan_q32(IDX);

    cordic_t stage_reg;
    cordic_t stage_next;
    cval_t   dx;
    cval_t   dy;

    assign dx = c_in.y >>> IDX;
    assign dy = c_in.x >>> IDX;

    always_comb begin
        if (c_in.z >= 0) begin
            stage_next.x = c_in.x - dx;
            stage_next.y = c_in.y + dy;
            stage_next.z = c_in.z - ATAN;
        end else begin
            stage_next.x = c_in.x + dx;
            stage_next.y = c_in.y - dy;
            stage_next.z = c_in.z + ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            stage_reg <= stage_next;
        end
    end

    assign c_out = stage_reg;

endmodule

// ----- rtl/hvd_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// hvd_sqrt_cell: one step of the bit-by-bit integer square root
// settles one result bit per cell
// ----------------------------------------------------------------------------
module hvd_sqrt_cell import hvd_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic  aclk,
    input  logic  en,
    input  sqrt_t s_in,
    output sqrt_t s_out
);

    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * IDX);

    sqrt_t       stage_reg;
    sqrt_t       stage_next;
    logic [63:0] trial;

    assign trial = s_in.res + BIT;

    always_comb begin
        stage_next.one = s_in.one;
        if (s_in.v >= trial) begin
            stage_next.v   = s_in.v - trial;
            stage_next.res = (s_in.res >> 1) + BIT;
        end else begin
            stage_next.v   = s_in.v;
            stage_next.res = s_in.res >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            stage_reg <= stage_next;
        end
    end

    assign s_out = stage_reg;

endmodule

// ----- rtl/hvd_vec_cell.sv -----
// ----------------------------------------------------------------------------
// hvd_vec_cell: one cordic vectoring step
// drives y towards zero and sums the angle, registered output
// ----------------------------------------------------------------------------
module hvd_vec_cell import hvd_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic    aclk,
    input  logic    en,
    input  cordic_t c_in,
    output cordic_t c_out
);

    localparam cval_t ATAN = atan_q32(IDX);

    cordic_t stage_reg;
    cordic_t stage_next;
    cval_t   dx;
    cval_t   dy;

    assign dx = c_in.y >>> IDX;
    assign dy = c_in.x >>> IDX;

    always_comb begin
        if (c_in.y > 0) begin
            stage_next.x = c_in.x + dx;
            stage_next.y = c_in.y - dy;
            stage_next.z = c_in.z + ATAN;
        end else begin
            stage_next.x = c_in.x - dx;
            stage_next.y = c_in.y + dy;
            stage_next.z = c_in.z - ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            stage_reg <= stage_next;
        end
    end

    assign c_out = stage_reg;

endmodule
